// File: rtl/tcw_pkg.sv
// Shared constants, command codes and queue entry type of the text console writer.
package tcw_pkg;

  localparam int unsigned ROWS       = 25;
  localparam int unsigned COLS       = 80;
  localparam int unsigned CELL_COUNT = ROWS * COLS;
  localparam int unsigned MOVE_COUNT = CELL_COUNT - COLS;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CELL_W = 11;
  localparam int unsigned DATA_W = 2 * BYTE_W;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [BYTE_W-1:0] DEFAULT_ATTR = 8'h0f;
  localparam logic [BYTE_W-1:0] NEWLINE_CHAR = 8'h0a;
  localparam logic [BYTE_W-1:0] SPACE_CHAR   = 8'h20;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_CLEAR = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_CLEAR,
    OP_READ,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e               op;
    logic [BYTE_W-1:0] character;
    logic [BYTE_W-1:0] attribute;
    logic              use_pos;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] idx;
  } q_item_t;

endpackage

// File: rtl/tcw_if.sv
// Command and result channel interfaces of the text console writer.
interface tcw_cmd_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [BYTE_W-1:0]   character;
  logic [BYTE_W-1:0]   attribute;
  logic                use_position;
  logic [COL_W-1:0]    column;
  logic [ROW_W-1:0]    line;

  modport source (output valid, cmd, character, attribute, use_position, column, line,
                  input ready);
  modport sink (input valid, cmd, character, attribute, use_position, column, line,
                output ready);
endinterface

interface tcw_res_if;
  import tcw_pkg::*;
  logic                valid;
  logic                ready;
  logic [CELL_W-1:0]   cursor_cell;
  logic                scrolled;
  logic [BYTE_W-1:0]   read_character;
  logic [BYTE_W-1:0]   read_attribute;

  modport source (output valid, cursor_cell, scrolled, read_character, read_attribute,
                  input ready);
  modport sink (input valid, cursor_cell, scrolled, read_character, read_attribute,
                output ready);
endinterface

// File: rtl/text_console_writer.sv
// Top level of the text console writer: front end, command queue and back end.
// A 25 x 80 character grid with a cursor. Commands enter through cmd_i and each
// one yields exactly one transaction on res_o, in order. The front end decodes a
// command in the cycle it is accepted and parks it in a two-entry queue, so up to
// two commands (plus one finished result waiting in the output register) can be
// held while the back end is busy. The back end runs one command at a time over
// the cell store (one read and one write port): put, newline and unused commands
// finish in the idle state unless they scroll, and a read passes through the read
// state (registered store read). The back end starts the next command only after
// the previous result has been taken. A put or newline that runs past the last
// row scrolls: the scroll state moves the 1920 cells below the top row up one row,
// one cell per cycle, then the fill state fills the bottom row with zeros. Clear
// writes all 2000 cells, one per cycle, before its result appears. The cell store
// is not initialized at reset; issue a clear before reading.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_cmd_if.sink   cmd_i,
  tcw_res_if.source res_o
);

  logic    push;
  logic    full;
  logic    pop;
  logic    q_valid;
  q_item_t push_item;
  q_item_t head_item;

  tcw_front u_front (
    .cmd_i  (cmd_i),
    .full_i (full),
    .push_o (push),
    .item_o (push_item)
  );

  tcw_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (head_item)
  );

  tcw_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .item_i  (head_item),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

// File: rtl/tcw_front.sv
// Front end: accepts commands, decodes them and resolves the given position.
module tcw_front
  import tcw_pkg::*;
(
  tcw_cmd_if.sink     cmd_i,
  input  logic        full_i,
  output logic        push_o,
  output q_item_t     item_o
);

  logic [COL_W-1:0] col_sat;
  logic [ROW_W-1:0] row_sat;

  assign cmd_i.ready = !full_i;
  assign push_o      = cmd_i.valid && !full_i;

  always_comb begin
    col_sat = (cmd_i.column >= COL_W'(COLS)) ? COL_W'(COLS - 1) : cmd_i.column;
    row_sat = (cmd_i.line >= ROW_W'(ROWS)) ? ROW_W'(ROWS - 1) : cmd_i.line;

    item_o.character = cmd_i.character;
    item_o.attribute = (cmd_i.attribute == '0) ? DEFAULT_ATTR : cmd_i.attribute;
    item_o.use_pos   = cmd_i.use_position;
    item_o.row       = row_sat;
    item_o.col       = col_sat;
    item_o.idx       = CELL_W'(CELL_W'(row_sat) * CELL_W'(COLS)) + CELL_W'(col_sat);

    case (cmd_i.cmd)
      CMD_PUT:   item_o.op = (cmd_i.character == NEWLINE_CHAR) ? OP_NEWLINE : OP_PUT;
      CMD_CLEAR: item_o.op = OP_CLEAR;
      CMD_READ:  item_o.op = OP_READ;
      default:   item_o.op = OP_NOP;
    endcase
  end

endmodule

// File: rtl/tcw_fifo.sv
// Short queue of decoded commands between front end and back end.
module tcw_fifo
  import tcw_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t item_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output q_item_t item_o
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  q_item_t           entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q;
  logic [QPTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0]  count_q;

  assign full_o  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// File: rtl/tcw_back.sv
// Back end: cell store, cursor, scroll and clear sequencer, result register.
module tcw_back
  import tcw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  q_item_t   item_i,
  output logic      pop_o,
  tcw_res_if.source res_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_FILL
  } state_e;

  state_e            state_q;
  logic [ROW_W-1:0]  cur_row_q;
  logic [COL_W-1:0]  cur_col_q;
  logic [CELL_W-1:0] cur_idx_q;
  logic [CELL_W-1:0] sweep_q;
  logic              wr_pend_q;
  logic [CELL_W-1:0] wr_addr_q;
  logic [CELL_W-1:0] fill_addr_q;
  logic [DATA_W-1:0] fill_data_q;
  logic              scroll_q;

  logic              out_valid_q;
  logic [CELL_W-1:0] out_cursor_q;
  logic              out_scrolled_q;
  logic [BYTE_W-1:0] out_char_q;
  logic [BYTE_W-1:0] out_attr_q;

  logic [DATA_W-1:0] mem [CELL_COUNT];
  logic [DATA_W-1:0] rd_data_q;
  logic              mem_we;
  logic [CELL_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [CELL_W-1:0] mem_raddr;

  logic              start;
  logic [ROW_W-1:0]  sel_row;
  logic [COL_W-1:0]  sel_col;
  logic [CELL_W-1:0] sel_idx;
  logic              is_nl;
  logic              wrap;
  logic [ROW_W-1:0]  nrow_raw;
  logic [CELL_W-1:0] nidx_raw;
  logic              do_scroll;
  logic [ROW_W-1:0]  nrow;
  logic [COL_W-1:0]  ncol;
  logic [CELL_W-1:0] nidx;

  assign start = (state_q == ST_IDLE) && valid_i && !out_valid_q;
  assign pop_o = start;

  assign res_o.valid          = out_valid_q;
  assign res_o.cursor_cell    = out_cursor_q;
  assign res_o.scrolled       = out_scrolled_q;
  assign res_o.read_character = out_char_q;
  assign res_o.read_attribute = out_attr_q;

  // Cursor kept as row, column and flat index so no division is needed.
  always_comb begin
    sel_row   = item_i.use_pos ? item_i.row : cur_row_q;
    sel_col   = item_i.use_pos ? item_i.col : cur_col_q;
    sel_idx   = item_i.use_pos ? item_i.idx : cur_idx_q;
    is_nl     = (item_i.op == OP_NEWLINE);
    wrap      = is_nl || (sel_col == COL_W'(COLS - 1));
    nrow_raw  = wrap ? sel_row + 1'b1 : sel_row;
    ncol      = wrap ? '0 : sel_col + 1'b1;
    nidx_raw  = is_nl ? sel_idx - CELL_W'(sel_col) + CELL_W'(COLS) : sel_idx + 1'b1;
    do_scroll = wrap && (nrow_raw == ROW_W'(ROWS));
    nrow      = do_scroll ? ROW_W'(ROWS - 1) : nrow_raw;
    nidx      = do_scroll ? nidx_raw - CELL_W'(COLS) : nidx_raw;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = fill_addr_q;
    mem_wdata = fill_data_q;
    mem_re    = 1'b0;
    mem_raddr = sel_idx;
    case (state_q)
      ST_IDLE: begin
        if (start && item_i.op == OP_PUT) begin
          mem_we    = 1'b1;
          mem_waddr = sel_idx;
          mem_wdata = {item_i.attribute, item_i.character};
        end
        if (start && item_i.op == OP_READ) begin
          mem_re = 1'b1;
        end
      end
      ST_SCROLL: begin
        // read one row ahead, write the previous read back one row up
        if (wr_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_q;
          mem_wdata = rd_data_q;
        end
        if (sweep_q < CELL_W'(MOVE_COUNT)) begin
          mem_re    = 1'b1;
          mem_raddr = sweep_q + CELL_W'(COLS);
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cur_row_q      <= '0;
      cur_col_q      <= '0;
      cur_idx_q      <= '0;
      sweep_q        <= '0;
      wr_pend_q      <= 1'b0;
      wr_addr_q      <= '0;
      fill_addr_q    <= '0;
      fill_data_q    <= '0;
      scroll_q       <= 1'b0;
      out_valid_q    <= 1'b0;
      out_cursor_q   <= '0;
      out_scrolled_q <= 1'b0;
      out_char_q     <= '0;
      out_attr_q     <= '0;
    end else begin
      if (out_valid_q && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (start) begin
            out_char_q <= '0;
            out_attr_q <= '0;
            case (item_i.op)
              OP_PUT, OP_NEWLINE: begin
                cur_row_q <= nrow;
                cur_col_q <= ncol;
                cur_idx_q <= nidx;
                if (do_scroll) begin
                  scroll_q  <= 1'b1;
                  sweep_q   <= '0;
                  wr_pend_q <= 1'b0;
                  state_q   <= ST_SCROLL;
                end else begin
                  out_valid_q    <= 1'b1;
                  out_cursor_q   <= nidx;
                  out_scrolled_q <= 1'b0;
                end
              end
              OP_CLEAR: begin
                cur_row_q   <= '0;
                cur_col_q   <= '0;
                cur_idx_q   <= '0;
                scroll_q    <= 1'b0;
                fill_addr_q <= '0;
                fill_data_q <= {DEFAULT_ATTR, SPACE_CHAR};
                state_q     <= ST_FILL;
              end
              OP_READ: begin
                state_q <= ST_READ;
              end
              default: begin
                out_valid_q    <= 1'b1;
                out_cursor_q   <= cur_idx_q;
                out_scrolled_q <= 1'b0;
              end
            endcase
          end
        end
        ST_READ: begin
          out_valid_q    <= 1'b1;
          out_cursor_q   <= cur_idx_q;
          out_scrolled_q <= 1'b0;
          out_char_q     <= rd_data_q[BYTE_W-1:0];
          out_attr_q     <= rd_data_q[DATA_W-1:BYTE_W];
          state_q        <= ST_IDLE;
        end
        ST_SCROLL: begin
          if (sweep_q < CELL_W'(MOVE_COUNT)) begin
            wr_pend_q <= 1'b1;
            wr_addr_q <= sweep_q;
            sweep_q   <= sweep_q + 1'b1;
          end else begin
            // last moved cell written this cycle; blank the bottom row next
            wr_pend_q   <= 1'b0;
            fill_addr_q <= CELL_W'(MOVE_COUNT);
            fill_data_q <= '0;
            state_q     <= ST_FILL;
          end
        end
        ST_FILL: begin
          if (fill_addr_q == CELL_W'(CELL_COUNT - 1)) begin
            out_valid_q    <= 1'b1;
            out_cursor_q   <= cur_idx_q;
            out_scrolled_q <= scroll_q;
            out_char_q     <= '0;
            out_attr_q     <= '0;
            state_q        <= ST_IDLE;
          end else begin
            fill_addr_q <= fill_addr_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
